>>> rtl/bounded_ordered_list_engine_core_assert.svh
// Assertion helpers for the ordered list engine.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// Check a property in the same cycle as its trigger
`define BOLE_ASSERT_NOW(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error(msg);

// Check a property in the cycle after its trigger
`define BOLE_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/bole_pkg.sv
package bole_pkg;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int TDATA_W = 40;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_DOWN_RD,
    S_DOWN_WR,
    S_RESP
  } state_t;

endpackage

>>> rtl/bounded_ordered_list_engine_core.sv
// Ordered list engine: keeps up to DEPTH signed 32-bit words in order plus a count.
// Input channel in_*: one command word per handshake; in_tuser carries the command
// (push, insert at index, remove first match, remove at index), in_tdata the value
// and position. Output channel out_*: exactly one result word per command with the
// removed value (zero otherwise), a status code and the count after the command.
// Entries sit in one single-port-write, registered-read RAM; a small sequencer moves
// them one at a time with a read state and a write state per entry.
// Work per command grows with the entries it moves: push stores at once; insert at p
// first moves the entries from p up by one; remove at p shifts the entries above p
// down by one; remove first match first reads entries from index 0 until a hit.
// One command is in flight at a time: in_tready is high only while the sequencer idles.
// The result sits in an output register, so a new command is accepted while the
// previous result still waits; if the receiver stalls longer, the next result holds
// the sequencer until the output register drains.
// Reset clears the count and the output valid; the entry RAM is not cleared because
// only entries below the count are ever read.
`include "bounded_ordered_list_engine_core_assert.svh"

module bounded_ordered_list_engine_core #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bole_pkg::TDATA_W-1:0]  in_tdata,   // [31:0] value, [36:32] position
  input  logic [bole_pkg::CMD_W-1:0]    in_tuser,   // [1:0] command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bole_pkg::TDATA_W-1:0]  out_tdata,  // [31:0] data, [36:32] count
  output logic [bole_pkg::STAT_W-1:0]   out_tuser   // [1:0] status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > bole_pkg::POS_W) ? CW : bole_pkg::POS_W;

  bole_pkg::state_t state_r, state_nxt;

  logic [bole_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [bole_pkg::DATA_W-1:0]  val_r, val_nxt;
  logic [bole_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [bole_pkg::DATA_W-1:0]  res_data_r, res_data_nxt;
  logic [bole_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [bole_pkg::DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [bole_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [bole_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [bole_pkg::DATA_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [bole_pkg::DATA_W-1:0]  ram_rdata;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic          full;
  logic          more;

  // Entry store
  bole_ram #(
    .WIDTH (bole_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared index arithmetic and compares
  assign pos_w   = PW'(pos_r);
  assign cnt_w   = PW'(cnt_r);
  assign idx_inc = idx_r + 1'b1;
  assign idx_dec = idx_r - 1'b1;
  assign full    = (cnt_r == CW'(DEPTH));
  assign more    = (idx_inc < cnt_r);

  assign in_tready  = (state_r == bole_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_data_r};
  assign out_tuser  = out_status_r;

  // Sequencer: next state, datapath updates and RAM control
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = idx_r[AW-1:0];

    // Drop the result word once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bole_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_tuser;
          val_nxt        = in_tdata[bole_pkg::DATA_W-1:0];
          pos_nxt        = in_tdata[bole_pkg::DATA_W +: bole_pkg::POS_W];
          res_data_nxt   = '0;
          res_status_nxt = bole_pkg::STAT_OK;
          state_nxt      = bole_pkg::S_DECODE;
        end
      end

      bole_pkg::S_DECODE: begin
        case (cmd_r)
          bole_pkg::CMD_PUSH: begin
            if (full) begin
              res_status_nxt = bole_pkg::STAT_FULL;
              state_nxt      = bole_pkg::S_RESP;
            end else begin
              idx_nxt   = cnt_r;
              state_nxt = bole_pkg::S_PUT;
            end
          end
          bole_pkg::CMD_INSERT: begin
            if (pos_w > cnt_w) begin
              res_status_nxt = bole_pkg::STAT_RANGE;
              state_nxt      = bole_pkg::S_RESP;
            end else if (full) begin
              res_status_nxt = bole_pkg::STAT_FULL;
              state_nxt      = bole_pkg::S_RESP;
            end else if (pos_w == cnt_w) begin
              idx_nxt   = CW'(pos_r);
              state_nxt = bole_pkg::S_PUT;
            end else begin
              idx_nxt   = cnt_r;
              state_nxt = bole_pkg::S_UP_RD;
            end
          end
          bole_pkg::CMD_REMOVE_VAL: begin
            if (cnt_r == '0) begin
              res_status_nxt = bole_pkg::STAT_NOTFOUND;
              state_nxt      = bole_pkg::S_RESP;
            end else begin
              idx_nxt   = '0;
              state_nxt = bole_pkg::S_SRCH_RD;
            end
          end
          default: begin
            if (pos_w >= cnt_w) begin
              res_status_nxt = bole_pkg::STAT_RANGE;
              state_nxt      = bole_pkg::S_RESP;
            end else begin
              idx_nxt   = CW'(pos_r);
              state_nxt = bole_pkg::S_SRCH_RD;
            end
          end
        endcase
      end

      // Open the gap: move entry idx-1 up to idx
      bole_pkg::S_UP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_dec[AW-1:0];
        state_nxt = bole_pkg::S_UP_WR;
      end

      bole_pkg::S_UP_WR: begin
        ram_we  = 1'b1;
        idx_nxt = idx_dec;
        if (PW'(idx_dec) == pos_w) begin
          state_nxt = bole_pkg::S_PUT;
        end else begin
          state_nxt = bole_pkg::S_UP_RD;
        end
      end

      // Store the new value at idx
      bole_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = bole_pkg::S_RESP;
      end

      // Walk for a match, or fetch the entry at the given index
      bole_pkg::S_SRCH_RD: begin
        ram_re    = 1'b1;
        state_nxt = bole_pkg::S_SRCH_CHK;
      end

      bole_pkg::S_SRCH_CHK: begin
        if (cmd_r == bole_pkg::CMD_REMOVE_AT || ram_rdata == val_r) begin
          res_data_nxt = ram_rdata;
          state_nxt    = bole_pkg::S_DOWN_RD;
        end else if (more) begin
          idx_nxt   = idx_inc;
          state_nxt = bole_pkg::S_SRCH_RD;
        end else begin
          res_status_nxt = bole_pkg::STAT_NOTFOUND;
          state_nxt      = bole_pkg::S_RESP;
        end
      end

      // Close the gap: move entry idx+1 down to idx
      bole_pkg::S_DOWN_RD: begin
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
          state_nxt = bole_pkg::S_DOWN_WR;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = bole_pkg::S_RESP;
        end
      end

      bole_pkg::S_DOWN_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = bole_pkg::S_DOWN_RD;
      end

      // Hand the result to the output register when it is free
      bole_pkg::S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = bole_pkg::COUNT_W'(cnt_r);
          state_nxt      = bole_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bole_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bole_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Checks
  `BOLE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "entry count above DEPTH")
  `BOLE_ASSERT_NOW(a_full_status, (state_r == bole_pkg::S_RESP) && (res_status_r == bole_pkg::STAT_FULL), full, "full status while list not full")
  `BOLE_ASSERT_NOW(a_data_zero, out_valid_r && (out_status_r != bole_pkg::STAT_OK), out_data_r == '0, "nonzero data on failed command")
  `BOLE_ASSERT_NEXT(a_put_count, state_r == bole_pkg::S_PUT, cnt_r == $past(cnt_r) + 1'b1, "store did not advance the count")
  `BOLE_ASSERT_NEXT(a_accept_decode, in_tvalid && in_tready, state_r == bole_pkg::S_DECODE, "accepted word not decoded")

endmodule

>>> rtl/bole_ram.sv
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

import bole_pkg::*;

// One predicted result word
typedef struct {
  logic [DATA_W-1:0]  data;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] count;
} list_reply_t;

// Shadow copy of the ordered list plus the queue of predicted result words
class list_scoreboard;
  logic [DATA_W-1:0] list_q[$];
  list_reply_t       reply_q[$];
  int                capacity;
  int                errors;
  int                cmd_seen[4];
  int                status_seen[4];
  int                peak_count;
  int                checked;

  function new(int capacity);
    this.capacity = capacity;
  endfunction

  // Apply an accepted command word to the shadow list and queue its result
  function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value,
                             logic [POS_W-1:0] pos);
    list_reply_t r;
    int idx;
    int hit;
    idx = int'(pos);
    hit = -1;
    r.data = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_PUSH: begin
        if (list_q.size() >= capacity) r.status = STAT_FULL;
        else list_q.push_back(value);
      end
      CMD_INSERT: begin
        if (idx > list_q.size()) r.status = STAT_RANGE;
        else if (list_q.size() >= capacity) r.status = STAT_FULL;
        else list_q.insert(idx, value);
      end
      CMD_REMOVE_VAL: begin
        // lowest-indexed match wins
        foreach (list_q[i]) begin
          if (hit < 0 && list_q[i] == value) hit = i;
        end
        if (hit < 0) begin
          r.status = STAT_NOTFOUND;
        end else begin
          r.data = list_q[hit];
          list_q.delete(hit);
        end
      end
      default: begin
        if (idx >= list_q.size()) begin
          r.status = STAT_RANGE;
        end else begin
          r.data = list_q[idx];
          list_q.delete(idx);
        end
      end
    endcase
    r.count = COUNT_W'(list_q.size());
    if (list_q.size() > peak_count) peak_count = list_q.size();
    cmd_seen[cmd]++;
    status_seen[r.status]++;
    reply_q.push_back(r);
  endfunction

  // Compare one result word with the oldest prediction
  function void check_result(logic [DATA_W-1:0] data, logic [STAT_W-1:0] status,
                             logic [COUNT_W-1:0] count);
    list_reply_t e;
    if (reply_q.size() == 0) begin
      $error("unexpected result word: data %h status %0d count %0d", data, status, count);
      errors++;
      return;
    end
    e = reply_q.pop_front();
    checked++;
    if (data !== e.data) begin
      $error("data mismatch: expected %h, actual %h", e.data, data);
      errors++;
    end
    if (status !== e.status) begin
      $error("status mismatch: expected %0d, actual %0d", e.status, status);
      errors++;
    end
    if (count !== e.count) begin
      $error("count mismatch: expected %0d, actual %0d", e.count, count);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int LIST_DEPTH   = 16;
  localparam int DRAIN_CYCLES = 4 * LIST_DEPTH + 20;
  localparam int STALL_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 600000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata;
  logic [CMD_W-1:0]     in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [TDATA_W-1:0]   out_tdata;
  logic [STAT_W-1:0]    out_tuser;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  cycle_count;
  list_scoreboard sb;

  bounded_ordered_list_engine_core #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Count cycles for the watchdog
  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random back-pressure, or a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[DATA_W-1:0], out_tuser, out_tdata[DATA_W+COUNT_W-1:DATA_W]);
  end

  // Offer one command word and hold it until accepted
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value,
                           logic [POS_W-1:0] pos);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {3'b000, pos, value};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, value, pos);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Wait until every predicted word has arrived, then let the engine settle
  task automatic drain();
    while (sb.reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Values: a small pool for duplicates, the extremes, or anything
  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return DATA_W'($signed($urandom_range(0, 6)) - 3);
    if (roll == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // Mostly well-formed commands with random content, some out of range
  task automatic run_random(int n);
    int grow_pct;
    int left;
    int sz;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  pos;
    left = 0;
    grow_pct = 50;
    repeat (n) begin
      // pick a new growth bias per episode
      if (left == 0) begin
        left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0: grow_pct = 80;
          1: grow_pct = 20;
          default: grow_pct = 50;
        endcase
      end
      left--;
      sz = sb.list_q.size();
      if ($urandom_range(0, 99) < grow_pct)
        cmd = ($urandom_range(0, 1) != 0) ? CMD_INSERT : CMD_PUSH;
      else
        cmd = ($urandom_range(0, 1) != 0) ? CMD_REMOVE_AT : CMD_REMOVE_VAL;
      value = pick_value();
      if (cmd == CMD_REMOVE_VAL && sz > 0 && $urandom_range(0, 99) < 75)
        value = sb.list_q[$urandom_range(0, sz - 1)];
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 31));
      else if (cmd == CMD_REMOVE_AT && sz > 0) pos = POS_W'($urandom_range(0, sz - 1));
      else pos = POS_W'($urandom_range(0, sz));
      send_word(cmd, value, pos);
    end
    go_idle();
  endtask

  initial begin
    sb = new(LIST_DEPTH);
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_PUSH;
    hold_req = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-list errors, extremes, duplicates, both removes
    send_word(CMD_REMOVE_AT, 32'h0, 5'd0);
    send_word(CMD_REMOVE_VAL, 32'h5, 5'd0);
    send_word(CMD_INSERT, 32'h1234_5678, 5'd1);
    send_word(CMD_INSERT, 32'h1, 5'd31);
    send_word(CMD_PUSH, 32'h8000_0000, 5'd0);
    send_word(CMD_PUSH, 32'h7fff_ffff, 5'd0);
    send_word(CMD_INSERT, 32'h0, 5'd0);
    send_word(CMD_INSERT, 32'hffff_ffff, 5'd3);
    send_word(CMD_INSERT, 32'h7fff_ffff, 5'd2);
    send_word(CMD_REMOVE_VAL, 32'h7fff_ffff, 5'd0);
    send_word(CMD_REMOVE_VAL, 32'h0001_2345, 5'd0);
    send_word(CMD_REMOVE_AT, 32'h0, 5'd4);
    send_word(CMD_REMOVE_AT, 32'h0, 5'd3);
    send_word(CMD_REMOVE_AT, 32'h0, 5'd0);
    send_word(CMD_REMOVE_AT, 32'h0, 5'd16);
    send_word(CMD_PUSH, 32'haaaa_aaaa, 5'd0);
    send_word(CMD_PUSH, 32'h5555_5555, 5'd0);
    send_word(CMD_REMOVE_VAL, 32'h5555_5555, 5'd0);
    go_idle();
    drain();

    send_idle_pct = 38;
    recv_idle_pct = 77;
    run_random(250);
    drain();

    // Hold off the receiver while filling the list to the top
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (LIST_DEPTH + 2) send_word(CMD_PUSH, $urandom(), 5'd0);
    send_word(CMD_INSERT, 32'h0bad_f00d, 5'd0);
    send_word(CMD_INSERT, 32'h0bad_f00d, 5'd17);
    send_word(CMD_INSERT, 32'h0bad_f00d, 5'd16);
    send_word(CMD_REMOVE_AT, 32'h0, 5'd15);
    go_idle();
    drain();

    send_idle_pct = 77;
    recv_idle_pct = 38;
    run_random(250);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(250);
    drain();

    $display("Run covered %0d commands (push %0d, insert %0d, remove-match %0d, remove-at %0d).",
             sb.checked, sb.cmd_seen[CMD_PUSH], sb.cmd_seen[CMD_INSERT],
             sb.cmd_seen[CMD_REMOVE_VAL], sb.cmd_seen[CMD_REMOVE_AT]);
    $display("Outcomes ok %0d, full %0d, range %0d, not found %0d; list peaked at %0d entries.",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_FULL], sb.status_seen[STAT_RANGE],
             sb.status_seen[STAT_NOTFOUND], sb.peak_count);
    if (sb.errors == 0 && sb.reply_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> bounded_ordered_list_engine_core.f
+incdir+rtl
rtl/bole_pkg.sv
rtl/bole_ram.sv
rtl/bounded_ordered_list_engine_core.sv
test/tb.sv
